// File: design/rco_pkg.sv
// rco_pkg: shared constants, result codes and the control/status structs
// for the rod cutting optimizer; no dependencies, used by every module
`timescale 1ns / 1ps

package rco_pkg;

   // longest rod handled in one run (1..63)
   localparam int MAX_LENGTH = 32;

   localparam int PRICE_W = 16;
   localparam int REV_W   = 22;
   // lengths 0..MAX_LENGTH
   localparam int LEN_W   = $clog2(MAX_LENGTH + 1);
   // store index 0..MAX_LENGTH-1
   localparam int ADDR_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

   // result kind codes
   localparam logic KIND_REVENUE = 1'b0;
   localparam logic KIND_PIECE   = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load_en;      // store the incoming price word
      logic issue;        // issue one compare-add step
      logic emit_rev;     // load the revenue word into the output register
      logic emit_piece;   // load one piece word into the output register
   } rco_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic load_final;   // the price being stored ends the run
      logic issue_last;   // the step being issued is the final one
      logic out_free;     // output register can take a word this cycle
      logic piece_final;  // the piece being emitted finishes the cut
   } rco_status_type;

endpackage

// File: design/rod_cutting_optimizer_unit.sv
// rod_cutting_optimizer_unit: rod cutting optimizer top level
// sequence: price words are stored while loading; after the last price come
// n(n+1)/2 compare-add steps and a drain state, then the revenue word, then a
// read state and an emit state per piece word; one run at a time, the solve
// paced by the single compare-add unit, one price and one revenue per cycle
// reset: synchronous; clears state, load count, pipeline valid, output valid
// depends on rco_pkg, rco_ctrl, rco_datapath
`timescale 1ns / 1ps

module rod_cutting_optimizer_unit (
   input  logic                        clock,
   input  logic                        reset,
   // price words
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rco_pkg::PRICE_W-1:0] req_piece_price,
   input  logic                        req_price_last,
   // result words: revenue, then the pieces of the cut
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_result_kind,
   output logic [rco_pkg::REV_W-1:0]   rsp_result_value,
   output logic                        rsp_result_last
);

   rco_pkg::rco_cmd_type    cmd;
   rco_pkg::rco_status_type status;

   // sequencer: load, solve over (j, i), drain, emit revenue, walk the cut
   rco_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, compare-add stage and output register
   rco_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_piece_price  (req_piece_price),
      .req_price_last   (req_price_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_result_value (rsp_result_value),
      .rsp_result_last  (rsp_result_last)
   );

endmodule

// File: design/rco_datapath.sv
// rco_datapath: price, revenue and first-piece stores, compare-add pipeline,
// backtrack length counter and output register; depends on rco_pkg
`timescale 1ns / 1ps

module rco_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  rco_pkg::rco_cmd_type            cmd,
   output rco_pkg::rco_status_type         status,
   input  logic [rco_pkg::PRICE_W-1:0]     req_piece_price,
   input  logic                            req_price_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_result_kind,
   output logic [rco_pkg::REV_W-1:0]       rsp_result_value,
   output logic                            rsp_result_last
);

   // memories
   logic [rco_pkg::PRICE_W-1:0] price_mem [rco_pkg::MAX_LENGTH];
   logic [rco_pkg::REV_W-1:0]   best_mem  [rco_pkg::MAX_LENGTH];
   logic [rco_pkg::LEN_W-1:0]   first_mem [rco_pkg::MAX_LENGTH];

   logic [rco_pkg::PRICE_W-1:0] price_rd_ff;
   logic [rco_pkg::REV_W-1:0]   best_rd_ff;
   logic [rco_pkg::LEN_W-1:0]   first_rd_ff;

   // load and loop counters
   logic [rco_pkg::LEN_W-1:0] count_ff, count_in;
   logic [rco_pkg::LEN_W-1:0] n_ff, n_in;
   logic [rco_pkg::LEN_W-1:0] j_ff, j_in;
   logic [rco_pkg::LEN_W-1:0] i_ff, i_in;
   logic [rco_pkg::LEN_W-1:0] count_inc;

   // accumulate stage
   logic                      s1_valid_ff;
   logic                      s1_first_ff;
   logic                      s1_last_ff;
   logic [rco_pkg::LEN_W-1:0] s1_i_ff;
   logic [rco_pkg::LEN_W-1:0] s1_j_ff;
   logic [rco_pkg::REV_W-1:0] acc_ff, acc_in;
   logic [rco_pkg::LEN_W-1:0] pick_ff, pick_in;
   logic [rco_pkg::REV_W-1:0] sum;
   logic                      take;

   // backtrack
   logic [rco_pkg::LEN_W-1:0] len_ff, len_in;
   logic [rco_pkg::LEN_W-1:0] piece;
   logic [rco_pkg::LEN_W-1:0] len_left;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_kind_ff;
   logic [rco_pkg::REV_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;

   // addresses
   logic [rco_pkg::LEN_W-1:0]  price_idx;
   logic [rco_pkg::LEN_W-1:0]  best_idx;
   logic [rco_pkg::LEN_W-1:0]  wr_idx;
   logic [rco_pkg::LEN_W-1:0]  first_idx;
   logic [rco_pkg::ADDR_W-1:0] price_addr;
   logic [rco_pkg::ADDR_W-1:0] best_addr;
   logic [rco_pkg::ADDR_W-1:0] wr_addr;
   logic [rco_pkg::ADDR_W-1:0] first_addr;
   logic [rco_pkg::ADDR_W-1:0] load_addr;

   assign count_inc  = count_ff + rco_pkg::LEN_W'(1);
   assign price_idx  = i_ff - rco_pkg::LEN_W'(1);
   // best[0] reads as zero, so the address is parked when i equals j
   assign best_idx   = (i_ff == j_ff) ? '0 : (j_ff - i_ff - rco_pkg::LEN_W'(1));
   assign wr_idx     = s1_j_ff - rco_pkg::LEN_W'(1);
   assign first_idx  = len_ff - rco_pkg::LEN_W'(1);
   assign price_addr = price_idx[rco_pkg::ADDR_W-1:0];
   assign best_addr  = best_idx[rco_pkg::ADDR_W-1:0];
   assign wr_addr    = wr_idx[rco_pkg::ADDR_W-1:0];
   assign first_addr = first_idx[rco_pkg::ADDR_W-1:0];
   assign load_addr  = count_ff[rco_pkg::ADDR_W-1:0];

   // status
   assign status.load_final  = req_price_last ||
                               (count_inc == rco_pkg::LEN_W'(rco_pkg::MAX_LENGTH));
   assign status.issue_last  = (i_ff == rco_pkg::LEN_W'(1)) && (j_ff == n_ff);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign status.piece_final = (len_left == '0);

   // memory ports
   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         price_mem[load_addr] <= req_piece_price;
      end
      if (s1_valid_ff && s1_last_ff) begin
         best_mem[wr_addr]  <= acc_in;
         first_mem[wr_addr] <= pick_in;
      end
      price_rd_ff <= price_mem[price_addr];
      best_rd_ff  <= best_mem[best_addr];
      first_rd_ff <= first_mem[first_addr];
   end

   // load count and loop indexes; i runs from j down to 1
   always_comb begin
      count_in = count_ff;
      n_in     = n_ff;
      j_in     = j_ff;
      i_in     = i_ff;
      if (cmd.load_en) begin
         if (status.load_final) begin
            count_in = '0;
            n_in     = count_inc;
            j_in     = rco_pkg::LEN_W'(1);
            i_in     = rco_pkg::LEN_W'(1);
         end else begin
            count_in = count_inc;
         end
      end else if (cmd.issue) begin
         if (i_ff == rco_pkg::LEN_W'(1)) begin
            j_in = j_ff + rco_pkg::LEN_W'(1);
            i_in = j_ff + rco_pkg::LEN_W'(1);
         end else begin
            i_in = i_ff - rco_pkg::LEN_W'(1);
         end
      end
   end

   // compare-add; >= keeps the smaller first piece on ties
   always_comb begin
      sum     = rco_pkg::REV_W'(price_rd_ff) + (s1_first_ff ? '0 : best_rd_ff);
      take    = s1_first_ff || (sum >= acc_ff);
      acc_in  = take ? sum : acc_ff;
      pick_in = take ? s1_i_ff : pick_ff;
   end

   // backtrack piece, guarded against out-of-range picks
   always_comb begin
      piece = first_rd_ff;
      if (first_rd_ff == '0 || first_rd_ff > len_ff) begin
         piece = len_ff;
      end
      len_left = len_ff - piece;
      len_in   = len_ff;
      if (cmd.emit_rev) begin
         len_in = n_ff;
      end else if (cmd.emit_piece) begin
         len_in = len_left;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_rev || cmd.emit_piece) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_valid_ff  <= cmd.issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      j_ff        <= j_in;
      i_ff        <= i_in;
      len_ff      <= len_in;
      s1_i_ff     <= i_ff;
      s1_j_ff     <= j_ff;
      s1_first_ff <= (i_ff == j_ff);
      s1_last_ff  <= (i_ff == rco_pkg::LEN_W'(1));
      if (s1_valid_ff) begin
         acc_ff  <= acc_in;
         pick_ff <= pick_in;
      end
      if (cmd.emit_rev) begin
         rsp_kind_ff  <= rco_pkg::KIND_REVENUE;
         rsp_value_ff <= acc_ff;
         rsp_last_ff  <= 1'b0;
      end else if (cmd.emit_piece) begin
         rsp_kind_ff  <= rco_pkg::KIND_PIECE;
         rsp_value_ff <= rco_pkg::REV_W'(piece);
         rsp_last_ff  <= (len_left == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_last  = rsp_last_ff;

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_rev || cmd.emit_piece) |-> (!rsp_valid_ff || rsp_ready))
      else $error("word loaded while output register held");

   a_piece_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_piece |-> (piece != '0 && piece <= len_ff))
      else $error("piece outside remaining length");

   a_load_idle_pipe: assert property (@(posedge clock) disable iff (reset)
      cmd.load_en |-> !s1_valid_ff)
      else $error("price stored while solve pipeline busy");

   a_issue_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (i_ff != '0 && i_ff <= j_ff && j_ff <= n_ff))
      else $error("loop index out of range");

endmodule

// File: design/rco_ctrl.sv
// rco_ctrl: sequencer for load, solve, drain and backtrack phases
// depends on rco_pkg for command and status structs
`timescale 1ns / 1ps

module rco_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rco_pkg::rco_status_type status,
   output rco_pkg::rco_cmd_type    cmd
);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_SOLVE = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_REV   = 3'd3;
   localparam logic [2:0] S_PRD   = 3'd4;
   localparam logic [2:0] S_POUT  = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_LOAD);

   always_comb begin
      state_in       = state_ff;
      cmd.load_en    = 1'b0;
      cmd.issue      = 1'b0;
      cmd.emit_rev   = 1'b0;
      cmd.emit_piece = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            cmd.load_en = req_valid;
            if (req_valid && status.load_final) begin
               state_in = S_SOLVE;
            end
         end
         S_SOLVE: begin
            cmd.issue = 1'b1;
            if (status.issue_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_REV;
         end
         S_REV: begin
            if (status.out_free) begin
               cmd.emit_rev = 1'b1;
               state_in     = S_PRD;
            end
         end
         S_PRD: begin
            state_in = S_POUT;
         end
         S_POUT: begin
            if (status.out_free) begin
               cmd.emit_piece = 1'b1;
               state_in       = status.piece_final ? S_LOAD : S_PRD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   a_solve_ends_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SOLVE && status.issue_last) |=> (state_ff == S_DRAIN))
      else $error("solve did not drain after final step");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> !cmd.load_en)
      else $error("price stored outside load phase");

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_rev && cmd.emit_piece))
      else $error("two words loaded at once");

endmodule
